// ----- rtl/bpmc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpmc_pkg
// Shared types, register indexes, reset values and the blink sequence table
// of the button press mode controller.
// ----------------------------------------------------------------------------
package bpmc_pkg;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_DEBOUNCE_COUNT  = 2'd0,
    CFG_LONG_THRESHOLD  = 2'd1,
    CFG_COUNTER_MAX     = 2'd2,
    CFG_ANIM_BRIGHTNESS = 2'd3
  } cfg_reg_t;

  localparam logic [5:0] DebounceReset   = 6'd10;
  localparam logic [5:0] LongThreshReset = 6'd40;
  localparam logic [5:0] CounterMaxReset = 6'd50;
  localparam logic [7:0] BrightnessReset = 8'h40;

  localparam logic [5:0] CountSat = 6'd63;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_RGB    = 2'd1,
    MODE_HSV    = 2'd2,
    MODE_SPARE  = 2'd3
  } ui_mode_t;

  typedef struct packed {
    logic [1:0] ui_mode;
    logic [1:0] channel_select;
    logic       static_on;
    logic       pressed_flag;
    logic       long_event;
    logic       short_event;
    logic       led_update;
    logic [7:0] led_red;
    logic [7:0] led_green;
    logic [7:0] led_blue;
  } bpmc_result_t;

  // lit-channel mask: bit 2 red, bit 1 green, bit 0 blue
  function automatic logic [2:0] seq_mask(input logic [2:0] sel, input logic [2:0] frm);
    logic [2:0] m;
    m = 3'd0;
    case (sel)
      3'd0: m = (frm == 3'd2 || frm == 3'd3) ? 3'd0 : 3'd4;
      3'd1: m = (frm == 3'd2 || frm == 3'd3) ? 3'd0 : 3'd2;
      3'd2: m = (frm == 3'd2 || frm == 3'd3) ? 3'd0 : 3'd1;
      3'd3: m = (frm == 3'd2 || frm == 3'd3) ? 3'd0 : 3'd6;
      3'd4: m = (frm == 3'd2 || frm == 3'd3) ? 3'd0 : 3'd3;
      3'd5: m = (frm == 3'd2 || frm == 3'd3) ? 3'd0 : 3'd5;
      3'd6: m = (frm < 3'd2) ? 3'd4 : ((frm < 3'd4) ? 3'd2 : 3'd1);
      default: m = (frm < 3'd2) ? 3'd6 : ((frm < 3'd4) ? 3'd3 : 3'd5);
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/bpmc_in_if.sv -----
// ----------------------------------------------------------------------------
// bpmc_in_if
// Tick channel: one raw button level per transaction.
// ----------------------------------------------------------------------------
interface bpmc_in_if;
  logic valid;
  logic ready;
  logic button_down;

  modport source (output valid, output button_down, input ready);
  modport sink   (input valid, input button_down, output ready);
endinterface

// ----- rtl/bpmc_out_if.sv -----
// ----------------------------------------------------------------------------
// bpmc_out_if
// Result channel: mode, flags, events and animation color per transaction.
// ----------------------------------------------------------------------------
interface bpmc_out_if;
  logic                   valid;
  logic                   ready;
  bpmc_pkg::bpmc_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/button_press_mode_controller_core.sv -----
// ----------------------------------------------------------------------------
// button_press_mode_controller_core
// Push-button debounce with short/long press detection, ui mode cycling and
// a blink animation driven from a sequence table.
// ----------------------------------------------------------------------------
// usage:
//   in_chan carries one raw button level per 10 ms tick. each accepted
//   transaction updates the press counter, debounced flag, mode, selected
//   channel and animation, and produces exactly one result on out_chan.
//   the result is registered and is valid the cycle after acceptance.
//   throughput is 1 tick per cycle while out_chan takes each result; the whole update is one pass of logic
//   from the state registers into the result register.
//   in_chan.ready is high while the result register is empty or being
//   taken, so a stalled receiver holds the result and back-pressures the
//   input after one pending result.
//   the cfg port writes a register at any edge with cfg_we high; write it
//   only while no tick is in flight.
//   reset (rst_n low, synchronous) loads the default register values,
//   clears the counters and flags, selects normal mode, arms the animation
//   and empties the result register.
// ----------------------------------------------------------------------------
module button_press_mode_controller_core #(
  parameter int unsigned ANIM_FRAMES = 6,
  parameter int unsigned FRAME_TICKS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bpmc_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [bpmc_pkg::CfgDataW-1:0]  cfg_wdata,
  bpmc_in_if.sink                        in_chan,
  bpmc_out_if.source                     out_chan
);

  localparam int unsigned SubW = $clog2(FRAME_TICKS + 1);
  localparam int unsigned FiW  = $clog2(ANIM_FRAMES + 1);

  // configuration registers
  logic [5:0] dbc_r, lth_r, cmax_r;
  logic [7:0] bright_r;

  // tick state
  logic [5:0]      press_count_r, press_count_nxt;
  logic [5:0]      held_ticks_r, held_ticks_nxt;
  logic            pushed_r, pushed_nxt;
  logic [1:0]      mode_r, mode_nxt;
  logic [1:0]      option_r, option_nxt;
  logic            static_r, static_nxt;
  logic [2:0]      seq_sel_r, seq_sel_nxt;
  // frame tick kept as frame index and tick within the frame
  logic [SubW-1:0] sub_tick_r, sub_tick_nxt;
  logic [FiW-1:0]  frame_idx_r, frame_idx_nxt;
  logic            anim_run_r, anim_run_nxt;

  logic                   out_valid_r;
  bpmc_pkg::bpmc_result_t res_r, res_nxt;

  logic                   accept;
  logic [5:0]             cnt_inc;
  logic signed [7:0]      cnt_dec;
  logic signed [7:0]      held_drop;
  logic                   long_ev, short_ev;
  logic [2:0]             mode_inc;
  logic [1:0]             mode_adv;
  logic [1:0]             option_adv;
  logic                   sub_wrap;
  logic [SubW-1:0]        sub_step;
  logic [FiW-1:0]         frm_step;
  logic [4:0]             frm_ext;
  logic [2:0]             frm_wrap;
  logic [2:0]             mask;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbc_r    <= bpmc_pkg::DebounceReset;
      lth_r    <= bpmc_pkg::LongThreshReset;
      cmax_r   <= bpmc_pkg::CounterMaxReset;
      bright_r <= bpmc_pkg::BrightnessReset;
    end else if (cfg_we) begin
      unique case (bpmc_pkg::cfg_reg_t'(cfg_addr))
        bpmc_pkg::CFG_DEBOUNCE_COUNT:  dbc_r    <= cfg_wdata[5:0];
        bpmc_pkg::CFG_LONG_THRESHOLD:  lth_r    <= cfg_wdata[5:0];
        bpmc_pkg::CFG_COUNTER_MAX:     cmax_r   <= cfg_wdata[5:0];
        bpmc_pkg::CFG_ANIM_BRIGHTNESS: bright_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    press_count_nxt = press_count_r;
    held_ticks_nxt  = held_ticks_r;
    pushed_nxt      = pushed_r;
    mode_nxt        = mode_r;
    option_nxt      = option_r;
    static_nxt      = static_r;
    seq_sel_nxt     = seq_sel_r;
    sub_tick_nxt    = sub_tick_r;
    frame_idx_nxt   = frame_idx_r;
    anim_run_nxt    = anim_run_r;
    long_ev         = 1'b0;
    short_ev        = 1'b0;

    cnt_inc    = (press_count_r == bpmc_pkg::CountSat) ? bpmc_pkg::CountSat
                                                       : press_count_r + 6'd1;
    cnt_dec    = $signed({2'b00, press_count_r}) - 8'sd1;
    held_drop  = $signed({2'b00, held_ticks_r}) - cnt_dec;
    mode_inc   = {1'b0, mode_r} + 3'd1;
    mode_adv   = (mode_inc >= 3'd3) ? 2'd0 : mode_inc[1:0];
    option_adv = (option_r >= 2'd2) ? 2'd0 : option_r + 2'd1;

    if (in_chan.button_down) begin
      held_ticks_nxt = cnt_inc;
      if (!pushed_r && cnt_inc == dbc_r) begin
        pushed_nxt = 1'b1;
      end
      if (cnt_inc == lth_r) begin
        long_ev  = 1'b1;
        mode_nxt = mode_adv;
        if (mode_adv == bpmc_pkg::MODE_NORMAL) begin
          static_nxt = 1'b0;
        end else begin
          static_nxt    = 1'b1;
          option_nxt    = 2'd0;
          seq_sel_nxt   = {1'b0, mode_adv} + 3'd5;
          sub_tick_nxt  = '0;
          frame_idx_nxt = '0;
          anim_run_nxt  = 1'b1;
        end
      end
      press_count_nxt = (cnt_inc > cmax_r) ? cmax_r : cnt_inc;
    end else begin
      if (pushed_r && (held_drop >= $signed({2'b00, dbc_r}) || cnt_dec == 8'sd1)) begin
        pushed_nxt = 1'b0;
        if (held_ticks_r < lth_r) begin
          short_ev = 1'b1;
          if (static_r) begin
            option_nxt = option_adv;
            // (mode + 7) * 3 folds to 3 * mode + 5 modulo 8
            seq_sel_nxt   = {1'b0, mode_r} * 3'd3 + 3'd5 + {1'b0, option_adv};
            sub_tick_nxt  = '0;
            frame_idx_nxt = '0;
            anim_run_nxt  = 1'b1;
          end
        end
      end
      press_count_nxt = (press_count_r == 6'd0) ? 6'd0 : press_count_r - 6'd1;
    end

    // animation runs on the updated state
    sub_wrap = (sub_tick_nxt == SubW'(FRAME_TICKS - 1));
    sub_step = sub_wrap ? '0 : sub_tick_nxt + SubW'(1);
    frm_step = sub_wrap ? frame_idx_nxt + FiW'(1) : frame_idx_nxt;
    frm_ext  = 5'(frm_step);
    frm_wrap = (frm_ext >= 5'd12) ? 3'(frm_ext - 5'd12)
             : (frm_ext >= 5'd6)  ? 3'(frm_ext - 5'd6) : 3'(frm_ext);
    mask     = bpmc_pkg::seq_mask(seq_sel_nxt, frm_wrap);

    res_nxt            = '0;
    if (mode_nxt != bpmc_pkg::MODE_NORMAL && anim_run_nxt) begin
      sub_tick_nxt  = sub_step;
      frame_idx_nxt = frm_step;
      if (frm_step >= FiW'(ANIM_FRAMES)) begin
        anim_run_nxt = 1'b0;
      end else begin
        res_nxt.led_update = 1'b1;
        res_nxt.led_red    = mask[2] ? bright_r : 8'd0;
        res_nxt.led_green  = mask[1] ? bright_r : 8'd0;
        res_nxt.led_blue   = mask[0] ? bright_r : 8'd0;
      end
    end

    res_nxt.ui_mode        = mode_nxt;
    res_nxt.channel_select = option_nxt;
    res_nxt.static_on      = static_nxt;
    res_nxt.pressed_flag   = pushed_nxt;
    res_nxt.long_event     = long_ev;
    res_nxt.short_event    = short_ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_count_r <= 6'd0;
      held_ticks_r  <= 6'd0;
      pushed_r      <= 1'b0;
      mode_r        <= bpmc_pkg::MODE_NORMAL;
      option_r      <= 2'd0;
      static_r      <= 1'b0;
      seq_sel_r     <= 3'd0;
      sub_tick_r    <= '0;
      frame_idx_r   <= '0;
      anim_run_r    <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        press_count_r <= press_count_nxt;
        held_ticks_r  <= held_ticks_nxt;
        pushed_r      <= pushed_nxt;
        mode_r        <= mode_nxt;
        option_r      <= option_nxt;
        static_r      <= static_nxt;
        seq_sel_r     <= seq_sel_nxt;
        sub_tick_r    <= sub_tick_nxt;
        frame_idx_r   <= frame_idx_nxt;
        anim_run_r    <= anim_run_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

endmodule
